// File: sv/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros shared by the retry backoff timer RTL
// Clocked on i_clk; the gated form is quiet while i_rst_n is low.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked only outside reset
`define RBJ_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// Property checked at every edge, reset included
`define RBJ_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

// File: sv/rbj_pkg.sv
// ----------------------------------------------------------------------------
// rbj_pkg
// Widths, constants and types of the retry backoff jitter timer.
// ----------------------------------------------------------------------------
`default_nettype none

package rbj_pkg;

    // Tracked slots and base retry interval in microseconds
    localparam int unsigned SLOTS       = 8;
    localparam int unsigned INTERVAL_US = 100000;

    // Field widths
    localparam int SLOT_W   = 3;
    localparam int TIME_W   = 48;
    localparam int GEN_W    = 32;
    localparam int CNT_W    = 8;
    localparam int LCG_W    = 32;
    localparam int MAXB_W   = 4;
    localparam int SLOT_IW  = (SLOTS > 1) ? $clog2(SLOTS) : 1;

    // Per-slot random generator
    localparam logic [LCG_W-1:0] LCG_MUL      = 32'd1664525;
    localparam logic [LCG_W-1:0] LCG_ADD      = 32'd1013904223;
    localparam int               JITTER_SHIFT = 16;
    localparam int               JIT_W        = LCG_W - JITTER_SHIFT;

    // Reset value of max_backoff
    localparam logic [MAXB_W-1:0] MAXB_RESET = 4'd5;

    // Saturation limits
    localparam logic [CNT_W-1:0]  CNT_MAX  = {CNT_W{1'b1}};
    localparam logic [TIME_W-1:0] TIME_MAX = {TIME_W{1'b1}};

    // One input beat
    typedef struct packed {
        logic [SLOT_W-1:0] slot;
        logic [TIME_W-1:0] now_time;
        logic [GEN_W-1:0]  change_generation;
        logic              waiting;
    } t_item;

    // Stored state of one slot
    typedef struct packed {
        logic [GEN_W-1:0]  gen;
        logic [CNT_W-1:0]  cnt;
        logic [LCG_W-1:0]  lcg;
        logic [TIME_W-1:0] nrt;
    } t_entry;

    // Flags from the scheduler
    typedef struct packed {
        logic due;
        logic woke;
    } t_sched_flags;

endpackage

`default_nettype wire

// File: sv/rbj_slot_tbl.sv
// ----------------------------------------------------------------------------
// rbj_slot_tbl
// Per-slot state held in flops: one combinational read port, one write port.
// ----------------------------------------------------------------------------
`default_nettype none

module rbj_slot_tbl (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic [rbj_pkg::SLOT_IW-1:0] i_rd_idx,
    output rbj_pkg::t_entry             o_rd_entry,
    input  wire logic                   i_wr_en,
    input  wire logic [rbj_pkg::SLOT_IW-1:0] i_wr_idx,
    input  wire rbj_pkg::t_entry        i_wr_entry
);
    import rbj_pkg::*;

    t_entry r_tbl [SLOTS];

    // Reset clears every slot: no generation seen, no retry scheduled
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < int'(SLOTS); i++) begin
                r_tbl[i] <= '0;
            end
        end else if (i_wr_en) begin
            r_tbl[i_wr_idx] <= i_wr_entry;
        end
    end

    assign o_rd_entry = r_tbl[i_rd_idx];

endmodule

`default_nettype wire

// File: sv/rbj_sched.sv
// ----------------------------------------------------------------------------
// rbj_sched
// Due decision and next-retry computation for one slot entry.
// ----------------------------------------------------------------------------
`default_nettype none

module rbj_sched (
    input  wire rbj_pkg::t_item         i_item,
    input  wire rbj_pkg::t_entry        i_entry,
    input  wire logic [rbj_pkg::MAXB_W-1:0] i_max_backoff,
    output rbj_pkg::t_entry             o_entry,
    output rbj_pkg::t_sched_flags       o_flags
);
    import rbj_pkg::*;

    localparam int SUM_W = TIME_W + 1;

    logic              woke;
    logic              due;
    logic [CNT_W-1:0]  cnt_base;
    logic [MAXB_W-1:0] exp_sel;
    logic [SUM_W-1:0]  backoff;
    logic [LCG_W-1:0]  lcg_new;
    logic [JIT_W-1:0]  rnd;
    logic [JIT_W-1:0]  jitter;
    logic [SUM_W-1:0]  sum;
    logic [TIME_W-1:0] t_sat;

    // Generation change restarts the backoff and wakes the slot at once
    assign woke = i_item.waiting && (i_item.change_generation != i_entry.gen);
    assign due  = i_item.waiting &&
                  (woke || (i_entry.nrt == '0) || (i_item.now_time >= i_entry.nrt));

    // Backoff exponent, capped
    assign cnt_base = woke ? '0 : i_entry.cnt;
    assign exp_sel  = (cnt_base > CNT_W'(i_max_backoff)) ? i_max_backoff
                                                         : cnt_base[MAXB_W-1:0];
    assign backoff  = SUM_W'(INTERVAL_US) << exp_sel;

    // Advance the generator; jitter comes from its upper half
    assign lcg_new = i_entry.lcg * LCG_MUL + LCG_ADD;
    assign rnd     = lcg_new[LCG_W-1:JITTER_SHIFT];

    // Jitter is rnd mod interval; identity when the interval exceeds rnd's range
    generate
        if (INTERVAL_US > ((1 << JIT_W) - 1)) begin : g_jit_pass
            assign jitter = rnd;
        end else begin : g_jit_mod
            // Floor reciprocal gives a quotient low by at most one
            localparam logic [32:0] RECIP = 33'((64'd1 << 32) / INTERVAL_US);
            logic [JIT_W+32:0] prod;
            logic [JIT_W:0]    quot;
            logic [JIT_W+33:0] qc;
            logic [JIT_W:0]    rem;
            assign prod   = (JIT_W+33)'(rnd) * (JIT_W+33)'(RECIP);
            assign quot   = prod[JIT_W+32:32];
            assign qc     = (JIT_W+34)'(quot) * (JIT_W+34)'(INTERVAL_US);
            assign rem    = (JIT_W+1)'(rnd) - qc[JIT_W:0];
            assign jitter = (rem >= (JIT_W+1)'(INTERVAL_US))
                          ? JIT_W'(rem - (JIT_W+1)'(INTERVAL_US)) : rem[JIT_W-1:0];
        end
    endgenerate

    // Next retry time, saturated at the top of the time range
    assign sum   = {1'b0, i_item.now_time} + backoff + SUM_W'(jitter);
    assign t_sat = sum[TIME_W] ? TIME_MAX : sum[TIME_W-1:0];

    // Updated entry
    always_comb begin
        o_entry = i_entry;
        if (due) begin
            o_entry.gen = i_item.change_generation;
            o_entry.cnt = (cnt_base == CNT_MAX) ? CNT_MAX : cnt_base + 1'b1;
            o_entry.lcg = lcg_new;
            o_entry.nrt = t_sat;
        end
    end

    assign o_flags.due  = due;
    assign o_flags.woke = woke;

endmodule

`default_nettype wire

// File: sv/retry_backoff_jitter_timer.sv
// ----------------------------------------------------------------------------
// retry_backoff_jitter_timer
// Per-slot retry scheduler with exponential backoff and random jitter.
// ----------------------------------------------------------------------------
// Takes one beat per clock while the output is not stalled and returns one
// result beat per input beat, in order, from an input register through an
// output register. The beat sits in the input register; the slot's state is
// read, updated and written back in the same cycle as the result is loaded
// into the output register, so a beat for the same slot in the very next
// cycle sees the updated state. Throughput is set by that read-modify-write
// of the per-slot flop table, which also holds the generator multiply and
// the 49-bit time sum. max_backoff is written on its own channel and is
// always ready; write it only while no beat is in flight.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module retry_backoff_jitter_timer (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    // Configuration
    input  wire logic                        i_cfg_valid,
    output logic                             o_cfg_ready,
    input  wire logic [rbj_pkg::MAXB_W-1:0]  i_cfg_max_backoff,
    // Input channel
    input  wire logic                        i_in_valid,
    output logic                             o_in_ready,
    input  wire logic [rbj_pkg::SLOT_W-1:0]  i_slot,
    input  wire logic [rbj_pkg::TIME_W-1:0]  i_now_time,
    input  wire logic [rbj_pkg::GEN_W-1:0]   i_change_generation,
    input  wire logic                        i_waiting,
    // Result channel
    output logic                             o_out_valid,
    input  wire logic                        i_out_ready,
    output logic                             o_due,
    output logic                             o_woke_on_change,
    output logic [rbj_pkg::TIME_W-1:0]       o_retry_time,
    output logic [rbj_pkg::CNT_W-1:0]        o_retry_number
);
    import rbj_pkg::*;

    logic              r_in_vld;
    t_item             r_item;
    logic              r_out_vld;
    logic              r_due;
    logic              r_woke;
    logic [TIME_W-1:0] r_time;
    logic [CNT_W-1:0]  r_num;
    logic [MAXB_W-1:0] r_max_backoff;

    logic              out_free;
    logic              fire;
    logic              slot_ok;
    logic [SLOT_IW-1:0] idx;
    t_entry            rd_entry;
    t_entry            upd_entry;
    t_sched_flags      flags;
    logic              n_due;
    logic              n_woke;
    logic [TIME_W-1:0] n_time;
    logic [CNT_W-1:0]  n_num;

    // Handshake: input stage moves on whenever the output register frees up
    assign out_free    = !r_out_vld || i_out_ready;
    assign fire        = r_in_vld && out_free;
    assign o_in_ready  = !r_in_vld || out_free;
    assign o_cfg_ready = 1'b1;

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld      <= 1'b0;
            r_out_vld     <= 1'b0;
            r_max_backoff <= MAXB_RESET;
        end else begin
            if (o_in_ready) begin
                r_in_vld <= i_in_valid;
            end
            if (out_free) begin
                r_out_vld <= r_in_vld;
            end
            if (i_cfg_valid) begin
                r_max_backoff <= i_cfg_max_backoff;
            end
        end
    end

    // Input register
    always_ff @(posedge i_clk) begin
        if (i_in_valid && o_in_ready) begin
            r_item.slot              <= i_slot;
            r_item.now_time          <= i_now_time;
            r_item.change_generation <= i_change_generation;
            r_item.waiting           <= i_waiting;
        end
    end

    // Slot lookup; slots beyond the table leave state alone and report zeros
    assign slot_ok = (32'(r_item.slot) < SLOTS);
    assign idx     = SLOT_IW'(r_item.slot);

    rbj_slot_tbl u_tbl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_rd_idx   (idx),
        .o_rd_entry (rd_entry),
        .i_wr_en    (fire && slot_ok),
        .i_wr_idx   (idx),
        .i_wr_entry (upd_entry)
    );

    rbj_sched u_sched (
        .i_item        (r_item),
        .i_entry       (rd_entry),
        .i_max_backoff (r_max_backoff),
        .o_entry       (upd_entry),
        .o_flags       (flags)
    );

    // Result beat
    assign n_due  = slot_ok && flags.due;
    assign n_woke = slot_ok && flags.due && flags.woke;
    assign n_time = slot_ok ? upd_entry.nrt : '0;
    assign n_num  = slot_ok ? upd_entry.cnt : '0;

    always_ff @(posedge i_clk) begin
        if (fire) begin
            r_due  <= n_due;
            r_woke <= n_woke;
            r_time <= n_time;
            r_num  <= n_num;
        end
    end

    assign o_out_valid      = r_out_vld;
    assign o_due            = r_due;
    assign o_woke_on_change = r_woke;
    assign o_retry_time     = r_time;
    assign o_retry_number   = r_num;

    // Checks
    `RBJ_ASSERT_ALWAYS(a_rst_empty, !i_rst_n |=> !o_out_valid && !r_in_vld, "pipe not empty after reset")
    `RBJ_ASSERT(a_woke_due, o_out_valid && o_woke_on_change |-> o_due, "woke without due")
    `RBJ_ASSERT(a_due_time, o_out_valid && o_due |-> o_retry_time != '0, "due with no retry time")
    `RBJ_ASSERT(a_due_count, o_out_valid && o_due |-> o_retry_number != '0, "due with zero count")
    `RBJ_ASSERT(a_fire_out, fire |=> o_out_valid, "committed beat not presented")

endmodule

`default_nettype wire
